FILE: src/assert_macros.svh
// Assertion helpers shared by the parser RTL.
// Each property is sampled on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond is never seen at a clock edge outside reset.
`define SFP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SFP_ASSERT(lbl, prop, msg)
`define SFP_NEVER(lbl, cond, msg)

`endif

`endif

FILE: src/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned MIN_FRAME_LEN = 3;
  localparam int unsigned MAX_FRAME_LEN = 64;
  localparam int unsigned FRAME_LEN_RST = 8;

  // Byte position of the command id within a frame, and of the first body byte.
  localparam logic [POS_W-1:0] POS_CMD = POS_W'(2);

  // Register index of the write port.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_FRAME_LEN   = 2'd2
  } sfp_reg_e;

  // Decoupling queue between the front and back halves.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified body byte on its way to the back half.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_pos;
    logic              frame_end;
    logic [BYTE_W-1:0] run_sum;   // sum of all earlier bytes of the frame
    logic [BYTE_W-1:0] cmd;       // command byte candidate
  } sfp_item_t;

endpackage

FILE: src/sfp_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfp_pkg::BYTE_W-1:0]  cfg_data_i,
  input  logic                        accept_i,
  input  logic [sfp_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                        item_push_o,
  output sfp_pkg::sfp_item_t          item_o
);
  import sfp_pkg::*;

  logic [BYTE_W-1:0] sync_first_q, sync_second_q;
  logic [LEN_W-1:0]  frame_len_q;

  logic              saw_first_q, saw_first_d;
  logic              in_frame_q, in_frame_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] held_q, held_d;

  logic [LEN_W-1:0]  len_m1;
  logic [POS_W-1:0]  last_pos;
  logic              is_last;
  logic [BYTE_W-1:0] cmd_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
      frame_len_q   <= LEN_W'(FRAME_LEN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        REG_FRAME_LEN:   frame_len_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame length, then take the position of the checksum byte.
  always_comb begin
    len_m1 = frame_len_q - LEN_W'(1);
    priority if (frame_len_q < LEN_W'(MIN_FRAME_LEN)) begin
      last_pos = POS_W'(MIN_FRAME_LEN - 1);
    end else if (frame_len_q > LEN_W'(MAX_FRAME_LEN)) begin
      last_pos = POS_W'(MAX_FRAME_LEN - 1);
    end else begin
      last_pos = len_m1[POS_W-1:0];
    end
  end

  assign is_last  = (cnt_q >= last_pos);
  assign cmd_byte = (cnt_q == POS_CMD) ? rx_byte_i : held_q;

  always_comb begin
    saw_first_d = saw_first_q;
    in_frame_d  = in_frame_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    held_d      = held_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        // Sync hunt: second byte wins over a fresh first byte.
        if (saw_first_q && (rx_byte_i == sync_second_q)) begin
          saw_first_d = 1'b0;
          in_frame_d  = 1'b1;
          cnt_d       = POS_CMD;
          sum_d       = sync_first_q + sync_second_q;
          held_d      = '0;
        end else begin
          saw_first_d = (rx_byte_i == sync_first_q);
        end
      end else if (is_last) begin
        in_frame_d = 1'b0;
        cnt_d      = '0;
        sum_d      = '0;
        held_d     = '0;
      end else begin
        if (cnt_q == POS_CMD) begin
          held_d = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        cnt_d = cnt_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_first_q <= 1'b0;
      in_frame_q  <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      held_q      <= '0;
    end else begin
      saw_first_q <= saw_first_d;
      in_frame_q  <= in_frame_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      held_q      <= held_d;
    end
  end

  assign item_push_o       = accept_i && in_frame_q;
  assign item_o.frame_byte = rx_byte_i;
  assign item_o.byte_pos   = cnt_q;
  assign item_o.frame_end  = is_last;
  assign item_o.run_sum    = sum_q;
  assign item_o.cmd        = cmd_byte;

  `SFP_NEVER(a_hunt_and_frame, saw_first_q && in_frame_q, "armed hunt inside a frame")
  `SFP_ASSERT(a_body_pos, in_frame_q |-> (cnt_q >= POS_CMD), "body position below header")
  `SFP_ASSERT(a_frame_closes, (accept_i && in_frame_q && is_last) |=> !in_frame_q,
              "frame did not close on its checksum byte")

endmodule

FILE: src/sfp_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enq_i,
  input  sfp_pkg::sfp_item_t enq_item_i,
  output logic               full_o,
  input  logic               deq_i,
  output logic               empty_o,
  output sfp_pkg::sfp_item_t deq_item_o
);
  import sfp_pkg::*;

  sfp_item_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_enq, do_deq;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_enq     = enq_i && !full_o;
  assign do_deq     = deq_i && !empty_o;
  assign deq_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    unique case ({do_enq, do_deq})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      entries_q[wr_ptr_q] <= enq_item_i;
    end
  end

  `SFP_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

FILE: src/sfp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  sfp_pkg::sfp_item_t         q_item_i,
  output logic                       q_deq_o,
  input  logic                       pop,
  output logic                       empty,
  output logic [sfp_pkg::BYTE_W-1:0] frame_byte_o,
  output logic [sfp_pkg::POS_W-1:0]  byte_pos_o,
  output logic                       frame_end_o,
  output logic                       sum_ok_o,
  output logic [sfp_pkg::BYTE_W-1:0] command_id_o
);
  import sfp_pkg::*;

  logic              valid_q;
  logic              take;
  logic              ok;
  logic [BYTE_W-1:0] byte_q;
  logic [POS_W-1:0]  pos_q;
  logic              end_q, ok_q;
  logic [BYTE_W-1:0] cmd_q;

  // Refill the output register whenever it is free or being drained.
  assign take = !q_empty_i && (!valid_q || pop);
  assign ok   = q_item_i.frame_end && (q_item_i.run_sum == q_item_i.frame_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= q_item_i.frame_byte;
      pos_q  <= q_item_i.byte_pos;
      end_q  <= q_item_i.frame_end;
      ok_q   <= ok;
      cmd_q  <= ok ? q_item_i.cmd : '0;
    end
  end

  assign q_deq_o      = take;
  assign empty        = !valid_q;
  assign frame_byte_o = byte_q;
  assign byte_pos_o   = pos_q;
  assign frame_end_o  = end_q;
  assign sum_ok_o     = ok_q;
  assign command_id_o = cmd_q;

  `SFP_ASSERT(a_status_only_at_end, (valid_q && !end_q) |-> (!ok_q && (cmd_q == '0)),
              "checksum status on a body byte")

endmodule

FILE: src/sync_frame_sum8_parser_unit.sv
`timescale 1ns / 1ps

// Two-byte sync frame parser with an 8-bit additive checksum. Received bytes
// enter through a queue-style port (push/full) and one byte is taken per
// clock cycle whenever full is low. The front half hunts for sync_first
// followed by sync_second (a repeated sync_first keeps the hunt armed),
// then counts the body of a frame of frame_len bytes (clamped to 3..64),
// keeps the running sum over header and body and latches the command byte at
// position 2. Header bytes give no transaction; every later byte gives one,
// carrying the byte and its position. On the checksum byte frame_end is set,
// sum_ok reports whether the sum matched and command_id holds the command
// byte, or zero on a mismatch. Results leave through empty/pop, oldest first.
// A result reaches the ports by way of the queue: the accepting edge writes it
// into the two-entry decoupling queue, and it moves on into the output register
// once that register is free or is being drained by pop. With pop held
// high the unit sustains one byte per cycle; full rises only once the queue
// and the output register are both occupied. Configuration writes (index 0:
// sync_first, 1: sync_second, 2: frame_len) take effect at the next edge.
module sync_frame_sum8_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfp_pkg::BYTE_W-1:0]    cfg_data_i,
  // received bytes
  input  logic                          push,
  output logic                          full,
  input  logic [sfp_pkg::BYTE_W-1:0]    rx_byte_i,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [sfp_pkg::BYTE_W-1:0]    frame_byte_o,
  output logic [sfp_pkg::POS_W-1:0]     byte_pos_o,
  output logic                          frame_end_o,
  output logic                          sum_ok_o,
  output logic [sfp_pkg::BYTE_W-1:0]    command_id_o
);
  import sfp_pkg::*;

  logic      accept;
  logic      item_push;
  sfp_item_t item;
  logic      q_full, q_empty, q_deq;
  sfp_item_t q_item;

  // Hold off the sender while the queue has no room, even for header bytes.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front half: sync hunt, position count, running sum.
  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .item_push_o (item_push),
    .item_o      (item)
  );

  // Decouple the byte stream from the result consumer.
  sfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (item_push),
    .enq_item_i (item),
    .full_o     (q_full),
    .deq_i      (q_deq),
    .empty_o    (q_empty),
    .deq_item_o (q_item)
  );

  // Back half: checksum compare, command selection, output register.
  sfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_item),
    .q_deq_o      (q_deq),
    .pop          (pop),
    .empty        (empty),
    .frame_byte_o (frame_byte_o),
    .byte_pos_o   (byte_pos_o),
    .frame_end_o  (frame_end_o),
    .sum_ok_o     (sum_ok_o),
    .command_id_o (command_id_o)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the two-byte sync frame parser.
// A byte stream is pushed in at the falling edge; every accepted byte is run
// through a local parser model, and whatever transaction that byte should
// produce is queued. Popped transactions are compared field by field against
// the head of that queue at the rising edge.
module testbench;
  import sfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  // Margin for a byte to pass through the queue into the output register.
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned NPHASE      = 12;
  // Index that no register answers to; writes there must leave the parser alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_pos;
    logic              frame_end;
    logic              sum_ok;
    logic [BYTE_W-1:0] command_id;
  } frame_out_t;

  typedef enum logic [1:0] {ROW_RX, ROW_RX_CHK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    data;
    frame_out_t           res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_data_i;
  logic                 push;
  logic                 full;
  logic [BYTE_W-1:0]    rx_byte_i;
  logic                 empty;
  logic                 pop;
  logic [BYTE_W-1:0]    frame_byte_o;
  logic [POS_W-1:0]     byte_pos_o;
  logic                 frame_end_o;
  logic                 sum_ok_o;
  logic [BYTE_W-1:0]    command_id_o;

  sync_frame_sum8_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .frame_byte_o (frame_byte_o),
    .byte_pos_o   (byte_pos_o),
    .frame_end_o  (frame_end_o),
    .sum_ok_o     (sum_ok_o),
    .command_id_o (command_id_o)
  );

  // Local copy of the registers
  logic [BYTE_W-1:0] cfg_sync_a;
  logic [BYTE_W-1:0] cfg_sync_b;
  logic [LEN_W-1:0]  cfg_len;

  // Local copy of the parser state
  logic              hunt_armed;
  logic              collecting;
  logic [LEN_W-1:0]  pos_cnt;
  logic [BYTE_W-1:0] sum8;
  logic [BYTE_W-1:0] cmd_hold;

  frame_out_t awaited_bytes[$];
  int unsigned n_err;
  int unsigned items_done;
  int unsigned push_idle_pct;
  int unsigned pop_idle_pct;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Clamp the length register to the range the parser honours.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    if (n < MIN_FRAME_LEN) return LEN_W'(MIN_FRAME_LEN);
    if (n > MAX_FRAME_LEN) return LEN_W'(MAX_FRAME_LEN);
    return n;
  endfunction

  // Advance the parser model by one byte; return 1 if a transaction is due.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output frame_out_t res);
    logic [LEN_W-1:0] last;
    res = '0;
    if (!collecting) begin
      // Header completion takes priority over re-arming on sync_first.
      if (hunt_armed && b == cfg_sync_b) begin
        hunt_armed = 1'b0;
        collecting = 1'b1;
        pos_cnt    = LEN_W'(POS_CMD);
        sum8       = cfg_sync_a + cfg_sync_b;
        cmd_hold   = '0;
      end else begin
        hunt_armed = (b == cfg_sync_a);
      end
      return 1'b0;
    end
    last           = eff_len(cfg_len) - 1'b1;
    res.frame_byte = b;
    res.byte_pos   = pos_cnt[POS_W-1:0];
    // A shortened length ends the frame at whatever position it has reached.
    if (pos_cnt >= last) begin
      res.frame_end  = 1'b1;
      res.sum_ok     = (sum8 == b);
      res.command_id = !res.sum_ok ? '0 : (pos_cnt == LEN_W'(POS_CMD)) ? b : cmd_hold;
      collecting = 1'b0;
      pos_cnt    = '0;
      sum8       = '0;
      cmd_hold   = '0;
    end else begin
      if (pos_cnt == LEN_W'(POS_CMD)) cmd_hold = b;
      sum8    = sum8 + b;
      pos_cnt = pos_cnt + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t rx_row(input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_RX;
    r.data = b;
    return r;
  endfunction

  // Byte row whose transaction is written out by hand.
  function automatic stim_row_t rx_chk(input logic [BYTE_W-1:0] b, input logic [POS_W-1:0] p,
                                       input logic fend, input logic ok,
                                       input logic [BYTE_W-1:0] cmd);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_RX_CHK;
    r.data = b;
    r.res  = '{frame_byte: b, byte_pos: p, frame_end: fend, sum_ok: ok, command_id: cmd};
    return r;
  endfunction

  function automatic stim_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Drop push and hold the input side quiet for a span set by n.
  task automatic go_quiet(input int unsigned n);
    @(negedge clk_i);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Offer one byte, wait for it to be taken, then queue its transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                           input frame_out_t typed_res = '0);
    frame_out_t res;
    bit         due;
    if ($urandom_range(99) < push_idle_pct) go_quiet($urandom_range(3, 1));
    @(negedge clk_i);
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    due = parse_byte(b, res);
    if (typed) awaited_bytes.push_back(typed_res);
    else if (due) awaited_bytes.push_back(res);
  endtask

  // Hold the input side until every queued transaction has been popped.
  task automatic wait_drained(input int unsigned extra);
    go_quiet(1);
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Registers are only written with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    wait_drained(SETTLE);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  cfg_sync_a = data;
      REG_SYNC_SECOND: cfg_sync_b = data;
      REG_FRAME_LEN:   cfg_len    = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Send one frame built from the current settings. A non-zero cut stops
  // after that many bytes; a bad checksum is drawn at random.
  task automatic send_frame(input int unsigned cut, input bit good);
    logic [BYTE_W-1:0] fr[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int unsigned       n;
    sum = cfg_sync_a + cfg_sync_b;
    fr.push_back(cfg_sync_a);
    fr.push_back(cfg_sync_b);
    for (int p = POS_CMD; p < eff_len(cfg_len) - 1; p++) begin
      b   = BYTE_W'($urandom);
      sum = sum + b;
      fr.push_back(b);
    end
    fr.push_back(good ? sum : BYTE_W'($urandom));
    n = (cut != 0 && cut < fr.size()) ? cut : fr.size();
    for (int i = 0; i < n; i++) begin
      send_byte(fr[i]);
      items_done++;
    end
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Sample every popped transaction at the rising edge and match it
  // against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    frame_out_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_bytes.size() == 0) begin
        n_err++;
        $display("%0t: unexpected transaction, expected none, got byte %h pos %0d",
                 $time, frame_byte_o, byte_pos_o);
      end else begin
        want = awaited_bytes.pop_front();
        check_field("frame_byte", want.frame_byte, frame_byte_o);
        check_field("byte_pos", BYTE_W'(want.byte_pos), BYTE_W'(byte_pos_o));
        check_field("frame_end", BYTE_W'(want.frame_end), BYTE_W'(frame_end_o));
        check_field("sum_ok", BYTE_W'(want.sum_ok), BYTE_W'(sum_ok_o));
        check_field("command_id", want.command_id, command_id_o);
      end
    end
  end

  // Receiver: pop in random bursts, and honour a long hold-off when asked.
  initial begin : receiver
    int unsigned pop_gap;
    int unsigned hold_cnt;
    pop      = 1'b0;
    pop_gap  = 0;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        pop <= 1'b0;
        hold_cnt--;
      end else if (pop_gap != 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else if ($urandom_range(99) < pop_idle_pct) begin
        pop <= 1'b0;
        pop_gap = $urandom_range(2, 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sync_frame_sum8_parser_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   directed[$];
    logic [6:0]  len_plan[NPHASE];
    int unsigned idle_plan[3];
    int unsigned goal;
    bit          paused;
    int unsigned r;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_SYNC_FIRST;
    cfg_data_i = '0;
    push       = 1'b0;
    rx_byte_i  = '0;
    hold_req   = 1'b0;
    n_err      = 0;
    items_done = 0;
    push_idle_pct = 20;
    pop_idle_pct  = 20;

    // Reset values of the registers and the parser.
    cfg_sync_a = '0;
    cfg_sync_b = '0;
    cfg_len    = LEN_W'(FRAME_LEN_RST);
    hunt_armed = 1'b0;
    collecting = 1'b0;
    pos_cnt    = '0;
    sum8       = '0;
    cmd_hold   = '0;

    // Length plan per phase: raw register values, out-of-range ones included.
    len_plan  = '{7'd5, 7'd3, 7'd64, 7'd0, 7'd4, 7'd72, 7'd7, 7'd2, 7'd127, 7'd9, 7'd65, 7'd6};
    idle_plan = '{0, 20, 45};

    directed = '{
      // Reset settings: sync 00/00, length 8; equal sync bytes complete the header.
      rx_row(8'h00), rx_row(8'h00),
      rx_chk(8'h5a, 6'd2, 1'b0, 1'b0, 8'h00),
      rx_chk(8'h01, 6'd3, 1'b0, 1'b0, 8'h00),
      rx_chk(8'hff, 6'd4, 1'b0, 1'b0, 8'h00),
      rx_chk(8'h00, 6'd5, 1'b0, 1'b0, 8'h00),
      rx_chk(8'h80, 6'd6, 1'b0, 1'b0, 8'h00),
      rx_chk(8'hda, 6'd7, 1'b1, 1'b1, 8'h5a),
      // Extreme sync values and the shortest frame; a repeated ff keeps the hunt armed.
      wr_row(REG_SYNC_FIRST, 8'hff), wr_row(REG_SYNC_SECOND, 8'h00),
      wr_row(REG_FRAME_LEN, 8'h03),
      rx_row(8'hff), rx_row(8'hff), rx_row(8'h00),
      rx_chk(8'hff, 6'd2, 1'b1, 1'b1, 8'hff),
      // Length zero acts as three; a bad checksum zeroes the command.
      wr_row(REG_FRAME_LEN, 8'h00),
      rx_row(8'h7e), rx_row(8'hff), rx_row(8'h00),
      rx_chk(8'h01, 6'd2, 1'b1, 1'b0, 8'h00),
      // Over-long length with bit 7 set; then shorten and move sync mid-frame.
      wr_row(REG_SYNC_FIRST, 8'ha5), wr_row(REG_SYNC_SECOND, 8'h5a),
      wr_row(REG_FRAME_LEN, 8'hc1),
      rx_row(8'ha5), rx_row(8'h5a), rx_row(8'h33), rx_row(8'hc4), rx_row(8'h08),
      wr_row(REG_FRAME_LEN, 8'h02), wr_row(REG_SYNC_FIRST, 8'h11),
      rx_chk(8'hfe, 6'd5, 1'b1, 1'b1, 8'h33),
      wr_row(REG_SPARE, 8'hff),
      wr_row(REG_FRAME_LEN, 8'h84),
      rx_row(8'h11), rx_row(8'h11), rx_row(8'h5a), rx_row(8'hff),
      rx_chk(8'h6a, 6'd3, 1'b1, 1'b1, 8'hff)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_WRITE:  write_reg(directed[i].idx, directed[i].data);
        ROW_RX_CHK: send_byte(directed[i].data, 1'b1, directed[i].res);
        default:    send_byte(directed[i].data);
      endcase
    end

    // Random phases: new settings each time, mostly well-formed frames.
    goal = 0;
    for (int p = 0; p < NPHASE; p++) begin
      case (p % 4)
        0: begin
          write_reg(REG_SYNC_FIRST, BYTE_W'($urandom));
          write_reg(REG_SYNC_SECOND, BYTE_W'($urandom));
        end
        1: begin
          r = $urandom_range(255);
          write_reg(REG_SYNC_FIRST, BYTE_W'(r));
          write_reg(REG_SYNC_SECOND, BYTE_W'(r));
        end
        2: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'hff);
        end
        default: begin
          write_reg(REG_SYNC_FIRST, 8'hff);
          write_reg(REG_SYNC_SECOND, 8'h00);
        end
      endcase
      // Phase 5 sets bit 7 on the length write; it must be dropped.
      write_reg(REG_FRAME_LEN, (p == 5) ? {1'b1, len_plan[p]} : {1'b0, len_plan[p]});

      // Quiet tail: no idling on either side in the last phase.
      push_idle_pct = (p == NPHASE - 1) ? 0 : idle_plan[p % 3];
      pop_idle_pct  = (p == NPHASE - 1) ? 0 : idle_plan[(p + 1) % 3];

      // Long receiver hold-off on a long-frame phase, so the unit backs up.
      if (p == 2) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end

      goal  += (eff_len(cfg_len) > 16) ? 60 : 145;
      paused = 1'b0;
      while (items_done < goal) begin
        // Once, pause the sender until every transaction has come out.
        if (p == 4 && !paused && items_done + 70 >= goal) begin
          paused = 1'b1;
          wait_drained(0);
        end
        r = $urandom_range(99);
        if (r < 15) begin
          send_byte(cfg_sync_a);
          items_done++;
        end
        if (r < 70) begin
          send_frame(0, $urandom_range(9) < 8);
        end else if (r < 85) begin
          send_frame($urandom_range(eff_len(cfg_len), 1), 1'b1);
        end else begin
          repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom));
        end
      end
      // End odd phases three bytes in; a longer frame stays open for the next writes.
      if (p % 2 == 1) send_frame(3, 1'b1);
    end

    wait_drained(2 * SETTLE);
    if (n_err == 0) $display("sync_frame_sum8_parser_unit: match");
    else $display("sync_frame_sum8_parser_unit: mismatch");
    $finish;
  end

endmodule
